### rtl/bfr_pkg.sv
// shared types, constants and the crc-8 byte update for the frame receiver
// no dependencies
`timescale 1ns / 1ps

package bfr_pkg;

    localparam logic [15:0] SYNC_WORD = 16'hAA55;
    localparam logic [7:0]  CRC_POLY  = 8'h07;

    localparam int BYTE_W = 8;
    localparam int CNT_W  = 17;

    // configuration register indexes
    localparam logic REG_EXPECTED_TYPE = 1'b0;
    localparam logic REG_EXPECTED_SIZE = 1'b1;

    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_HEADER  = 3'd1,
        PH_PAYLOAD = 3'd2,
        PH_CRC     = 3'd3,
        PH_SKIP    = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_CRC_ERR  = 2'd1,
        ST_TYPE_ERR = 2'd2,
        ST_SIZE_ERR = 2'd3
    } status_t;

    localparam logic KIND_DATA    = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    typedef struct packed {
        logic                valid;
        logic                kind;
        logic [BYTE_W-1:0]   data;
        status_t             status;
        logic                last;
    } res_t;

    // msb-first crc-8, no reflection
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            if (c[7])
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

### rtl/bfr_parser.sv
// frame parser: sync hunt, header check, payload pass-through and crc verdict
// depends on bfr_pkg
`timescale 1ns / 1ps

module bfr_parser (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      step,
    input  logic [7:0]                rx,
    input  logic [15:0]               cfg_type,
    input  logic [15:0]               cfg_size,
    output bfr_pkg::res_t             res
);
    import bfr_pkg::*;

    phase_t              phase_reg, phase_next;
    logic [BYTE_W-1:0]   prev_byte_reg, prev_byte_next;
    logic                prev_valid_reg, prev_valid_next;
    logic [23:0]         hdr_reg, hdr_next;
    logic [1:0]          hcnt_reg, hcnt_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [7:0]          crc_reg, crc_next;

    logic [31:0]         hdr_full;
    logic [15:0]         hdr_type;
    logic [15:0]         hdr_size;
    logic [CNT_W-1:0]    cnt_dec;

    assign hdr_full = {rx, hdr_reg};
    assign hdr_type = hdr_full[15:0];
    assign hdr_size = hdr_full[31:16];
    assign cnt_dec  = cnt_reg - CNT_W'(1);

    always_comb
    begin
        phase_next      = phase_reg;
        prev_byte_next  = prev_byte_reg;
        prev_valid_next = prev_valid_reg;
        hdr_next        = hdr_reg;
        hcnt_next       = hcnt_reg;
        cnt_next        = cnt_reg;
        crc_next        = crc_reg;
        res             = '0;
        res.status      = ST_OK;
        if (step)
        begin
            unique case (phase_reg)
                PH_HEADER:
                begin
                    hdr_next = hdr_full[31:8];
                    if (hcnt_reg != 2'd3)
                    begin
                        hcnt_next = hcnt_reg + 2'd1;
                    end
                    else
                    begin
                        hcnt_next = 2'd0;
                        if (hdr_type != cfg_type || hdr_size != cfg_size)
                        begin
                            phase_next = PH_SKIP;
                            cnt_next   = {1'b0, hdr_size} + CNT_W'(1);
                            res.valid  = 1'b1;
                            res.kind   = KIND_VERDICT;
                            res.status = (hdr_type != cfg_type) ? ST_TYPE_ERR
                                                                : ST_SIZE_ERR;
                        end
                        else
                        begin
                            crc_next   = 8'd0;
                            cnt_next   = {1'b0, hdr_size};
                            phase_next = (hdr_size == 16'd0) ? PH_CRC : PH_PAYLOAD;
                        end
                    end
                end
                PH_PAYLOAD:
                begin
                    crc_next = crc8_byte(crc_reg, rx);
                    cnt_next = cnt_dec;
                    if (cnt_dec == '0)
                        phase_next = PH_CRC;
                    res.valid = 1'b1;
                    res.kind  = KIND_DATA;
                    res.data  = rx;
                end
                PH_CRC:
                begin
                    phase_next      = PH_HUNT;
                    prev_valid_next = 1'b0;
                    prev_byte_next  = '0;
                    res.valid       = 1'b1;
                    res.kind        = KIND_VERDICT;
                    res.status      = (rx == crc_reg) ? ST_OK : ST_CRC_ERR;
                    res.last        = 1'b1;
                end
                PH_SKIP:
                begin
                    cnt_next = cnt_dec;
                    if (cnt_dec == '0)
                    begin
                        phase_next      = PH_HUNT;
                        prev_valid_next = 1'b0;
                        prev_byte_next  = '0;
                    end
                end
                default:
                begin
                    // sliding two-byte window, 0x55 then 0xaa
                    if (prev_valid_reg && {rx, prev_byte_reg} == SYNC_WORD)
                    begin
                        phase_next      = PH_HEADER;
                        hcnt_next       = 2'd0;
                        hdr_next        = '0;
                        prev_valid_next = 1'b0;
                        prev_byte_next  = '0;
                    end
                    else
                    begin
                        phase_next      = PH_HUNT;
                        prev_byte_next  = rx;
                        prev_valid_next = 1'b1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HUNT;
            prev_byte_reg  <= '0;
            prev_valid_reg <= 1'b0;
            hdr_reg        <= '0;
            hcnt_reg       <= '0;
            cnt_reg        <= '0;
            crc_reg        <= '0;
        end
        else
        begin
            phase_reg      <= phase_next;
            prev_byte_reg  <= prev_byte_next;
            prev_valid_reg <= prev_valid_next;
            hdr_reg        <= hdr_next;
            hcnt_reg       <= hcnt_next;
            cnt_reg        <= cnt_next;
            crc_reg        <= crc_next;
        end
    end

endmodule

### rtl/binary_frame_receiver_crc8_core.sv
// top level of the sync-word frame receiver with crc-8 check
// depends on bfr_pkg and bfr_parser
`timescale 1ns / 1ps

// usage
// input channel: in_valid / in_stall carry one received byte (rx_byte) per word.
// output channel: out_valid / out_stall carry one result word: a payload byte
//   (kind 0, data_byte) or a frame verdict (kind 1, status, last).
// a word is taken at a rising edge where valid is high and stall is low.
// configuration: cfg_wr_en writes cfg_data to the register at cfg_index
//   (0 expected type, 1 expected size); write only while the block is idle.
// path: an accepted byte is held in the input register and parsed at an edge
//   where the output can advance; its result word, if any, enters out_reg there.
// throughput: one byte per cycle unless out_stall holds a result; a parser
//   step is one pass through the header compare or the unrolled crc-8 update.
// many bytes (sync, header, skipped bytes) give no result word.
// reset: no word held, config and parser registers cleared to 0, parser hunting for sync.
// stall: while out_stall holds a waiting result, the parser stops and
//   in_stall rises once the input register is full; nothing is dropped.

module binary_frame_receiver_crc8_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        kind,
    output logic [7:0]  data_byte,
    output logic [1:0]  status,
    output logic        last,
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);
    import bfr_pkg::*;

    logic [15:0]       exp_type_reg;
    logic [15:0]       exp_size_reg;
    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              out_valid_reg;
    res_t              out_reg;
    res_t              res;
    logic              adv;
    logic              step;

    // output register free or being emptied this cycle
    assign adv      = !out_valid_reg || !out_stall;
    assign step     = in_valid_reg && adv;
    assign in_stall = in_valid_reg && !adv;

    bfr_parser u_parser (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (step),
        .rx       (in_byte_reg),
        .cfg_type (exp_type_reg),
        .cfg_size (exp_size_reg),
        .res      (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_type_reg <= '0;
            exp_size_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_EXPECTED_TYPE: exp_type_reg <= cfg_data;
                REG_EXPECTED_SIZE: exp_size_reg <= cfg_data;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_valid && !in_stall)
            in_valid_reg <= 1'b1;
        else if (adv)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            in_byte_reg <= rx_byte;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= step && res.valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            out_reg <= res;
    end

    assign out_valid = out_valid_reg;
    assign kind      = out_reg.kind;
    assign data_byte = out_reg.data;
    assign status    = out_reg.status;
    assign last      = out_reg.last;

endmodule

### rtl/bfr_checker.sv
// port-level checks on the frame receiver output words
// depends on binary_frame_receiver_crc8_core (bound to it below)
`timescale 1ns / 1ps

module bfr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic        kind,
    input logic [7:0]  data_byte,
    input logic [1:0]  status,
    input logic        last
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(kind) && $stable(data_byte)
            && $stable(status) && $stable(last))
        else $error("stalled output word changed");

    a_data_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !kind |-> status == 2'd0 && !last)
        else $error("payload word carries verdict bits");

    a_verdict_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind |-> data_byte == 8'd0)
        else $error("verdict word carries data");

    a_last_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last |-> kind && (status == 2'd0 || status == 2'd1))
        else $error("frame end on a word that is not a crc verdict");

    a_no_stall_empty: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled while output free");

endmodule

bind binary_frame_receiver_crc8_core bfr_checker u_bfr_checker (.*);
